[src/switched_torque_limit_scheduler_core_assert.svh]
// Assertion macros for the torque limit scheduler checker.
`ifndef SWITCHED_TORQUE_LIMIT_SCHEDULER_CORE_ASSERT_SVH
`define SWITCHED_TORQUE_LIMIT_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/stls_pkg.sv]
// Shared widths, register indexes and reset values of the torque limit scheduler.
package stls_pkg;

	// Item field widths.
	localparam int JOINT_W = 2;
	localparam int ANGLE_W = 32;
	localparam int LIMIT_W = 32;

	// Stream data widths, padded to whole bytes.
	localparam int S_FIELDS_W = JOINT_W + 2 * ANGLE_W;
	localparam int S_DATA_W = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = JOINT_W + LIMIT_W;
	localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register widths.
	localparam int HOLD_W = 16;
	localparam int FACTOR_W = 17;
	localparam int EPS_W = 16;
	localparam int TICK_W = 16;

	// Register indexes.
	localparam cfg_idx_t REG_SWITCH_LIMIT = 3'd0;
	localparam cfg_idx_t REG_STEADY_LIMIT = 3'd1;
	localparam cfg_idx_t REG_HOLD_TICKS = 3'd2;
	localparam cfg_idx_t REG_DECAY_FACTOR = 3'd3;
	localparam cfg_idx_t REG_TARGET_EPS = 3'd4;

	// Register reset values.
	localparam logic [LIMIT_W-1:0] SWITCH_LIMIT_RST = 32'd13107200;
	localparam logic [LIMIT_W-1:0] STEADY_LIMIT_RST = 32'd3276800;
	localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 16'd1000;
	localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST = 17'd65014;
	localparam logic [EPS_W-1:0] TARGET_EPS_RST = 16'd7;

	typedef logic [TICK_W-1:0] tick_t;
	localparam tick_t TICK_MAX = 16'hFFFF;

endpackage

[src/switched_torque_limit_scheduler_core.sv]
// Switched torque limit scheduler: per-joint switch tracking with a shared multiplier.
// Sequence: IDLE takes the item, EVAL evaluates it, DONE loads the output register; ticks
// past the hold period add MUL_DECAY, UPD_DECAY, MUL_SCALE and SUM; a stalled result
// holds the sequencer until it is taken. A new item is taken only once the last result is
// loaded; the single multiplier is used twice in turn (decay update, then excess scaling).
// Reset: asynchronous; registers take their default values and joint state is cleared.
module switched_torque_limit_scheduler_core #(
	parameter int NUM_JOINTS = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// Configuration write port.
	input  logic cfg_we,
	input  stls_pkg::cfg_idx_t cfg_index,
	input  logic [stls_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input items.
	input  logic s_tvalid,
	output logic s_tready,
	// s_tdata, low bit up: joint[1:0], cmd_angle[33:2], measured_angle[65:34], zero pad.
	input  logic [stls_pkg::S_DATA_W-1:0] s_tdata,
	// Result items.
	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata, low bit up: joint_out[1:0], limit_out[33:2], zero pad.
	output logic [stls_pkg::M_DATA_W-1:0] m_tdata
);
	import stls_pkg::*;

	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int DW = FRAC_BITS + 1;
	localparam int CW = (DW > FACTOR_W) ? DW : FACTOR_W;
	localparam int PW = LIMIT_W + DW;
	localparam int RW = PW + 1 - FRAC_BITS;
	localparam int SUM_W = LIMIT_W + 3;
	localparam int M_PAD_W = M_DATA_W - M_FIELDS_W;
	localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;
	localparam logic [PW:0] HALF_Q = (PW + 1)'(1) << (FRAC_BITS - 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_MUL_DECAY = 3'd2;
	localparam logic [2:0] ST_UPD_DECAY = 3'd3;
	localparam logic [2:0] ST_MUL_SCALE = 3'd4;
	localparam logic [2:0] ST_SUM = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;

	logic [LIMIT_W-1:0] switch_limit_q;
	logic [LIMIT_W-1:0] steady_limit_q;
	logic [HOLD_W-1:0] hold_ticks_q;
	logic [FACTOR_W-1:0] decay_factor_q;
	logic [EPS_W-1:0] target_eps_q;

	logic [ANGLE_W-1:0] last_tgt_q [NUM_JOINTS];
	tick_t tick_q [NUM_JOINTS];
	logic active_q [NUM_JOINTS];
	logic [DW-1:0] decay_q [NUM_JOINTS];

	logic [JOINT_W-1:0] joint_q;
	logic [ANGLE_W-1:0] tgt_q;
	logic [ANGLE_W-1:0] meas_q;
	logic [LIMIT_W-1:0] steady_q;
	logic [LIMIT_W-1:0] excess_q;
	logic [LIMIT_W-1:0] res_q;
	logic [PW-1:0] prod_q;

	logic m_valid_q;
	logic [JOINT_W-1:0] m_joint_q;
	logic [LIMIT_W-1:0] m_limit_q;

	logic [JW-1:0] idx;
	logic in_range;
	logic signed [SUM_W-1:0] steady_sum;
	logic [LIMIT_W-1:0] steady_c;
	logic [LIMIT_W-1:0] excess_c;
	logic signed [ANGLE_W:0] tgt_diff;
	logic [ANGLE_W:0] tgt_mag;
	logic is_switch;
	tick_t tick_next;
	logic [DW-1:0] factor_c;
	logic [LIMIT_W-1:0] mul_a;
	logic [DW-1:0] mul_b;
	logic [PW-1:0] prod_c;
	logic [PW:0] rnd_sum;
	logic [RW-1:0] rnd_c;
	logic [SUM_W-1:0] total_c;
	logic out_load;

	assign idx = JW'(joint_q);
	assign in_range = 32'(joint_q) < 32'(NUM_JOINTS);

	// Steady limit: base plus angle error, floored at zero and saturated.
	assign steady_sum = $signed(SUM_W'(steady_limit_q))
		+ SUM_W'($signed(tgt_q)) - SUM_W'($signed(meas_q));
	always_comb begin
		if (steady_sum < 0) begin
			steady_c = '0;
		end else if (steady_sum[SUM_W-1:LIMIT_W] != '0) begin
			steady_c = '1;
		end else begin
			steady_c = steady_sum[LIMIT_W-1:0];
		end
	end
	assign excess_c = (switch_limit_q > steady_c) ? (switch_limit_q - steady_c) : '0;

	// Switch test on the exact target move.
	assign tgt_diff = $signed({tgt_q[ANGLE_W-1], tgt_q})
		- $signed({last_tgt_q[idx][ANGLE_W-1], last_tgt_q[idx]});
	assign tgt_mag = tgt_diff[ANGLE_W] ? (~tgt_diff + 1'b1) : tgt_diff;
	assign is_switch = tgt_mag > (ANGLE_W + 1)'(target_eps_q);
	assign tick_next = (tick_q[idx] == TICK_MAX) ? tick_q[idx] : tick_q[idx] + 1'b1;

	// Decay factor above one acts as one.
	assign factor_c = (CW'(decay_factor_q) > CW'(ONE_Q)) ? ONE_Q : DW'(decay_factor_q);

	// Shared multiplier: decay update first, then excess scaling.
	assign mul_a = (state_q == ST_MUL_DECAY) ? LIMIT_W'(decay_q[idx]) : excess_q;
	assign mul_b = (state_q == ST_MUL_DECAY) ? factor_c : decay_q[idx];
	assign prod_c = PW'(mul_a) * PW'(mul_b);

	// Round half up and drop the fraction.
	assign rnd_sum = {1'b0, prod_q} + HALF_Q;
	assign rnd_c = rnd_sum[PW:FRAC_BITS];
	assign total_c = SUM_W'(steady_q) + SUM_W'(rnd_c);

	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_limit_q <= SWITCH_LIMIT_RST;
			steady_limit_q <= STEADY_LIMIT_RST;
			hold_ticks_q <= HOLD_TICKS_RST;
			decay_factor_q <= DECAY_FACTOR_RST;
			target_eps_q <= TARGET_EPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SWITCH_LIMIT: switch_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_STEADY_LIMIT: steady_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_HOLD_TICKS: hold_ticks_q <= cfg_data[HOLD_W-1:0];
				REG_DECAY_FACTOR: decay_factor_q <= cfg_data[FACTOR_W-1:0];
				REG_TARGET_EPS: target_eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and per-joint state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_JOINTS; i++) begin
				last_tgt_q[i] <= '0;
				tick_q[i] <= '0;
				active_q[i] <= 1'b0;
				decay_q[i] <= ONE_Q;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_DONE;
					if (in_range) begin
						if (is_switch) begin
							last_tgt_q[idx] <= tgt_q;
							tick_q[idx] <= '0;
							active_q[idx] <= 1'b1;
							decay_q[idx] <= ONE_Q;
						end else if (active_q[idx]) begin
							tick_q[idx] <= tick_next;
							if (tick_next > hold_ticks_q) begin
								state_q <= ST_MUL_DECAY;
							end
						end
					end
				end
				ST_MUL_DECAY: state_q <= ST_UPD_DECAY;
				ST_UPD_DECAY: begin
					decay_q[idx] <= rnd_c[DW-1:0];
					state_q <= ST_MUL_SCALE;
				end
				ST_MUL_SCALE: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and working registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			joint_q <= s_tdata[JOINT_W-1:0];
			tgt_q <= s_tdata[JOINT_W+ANGLE_W-1:JOINT_W];
			meas_q <= s_tdata[JOINT_W+2*ANGLE_W-1:JOINT_W+ANGLE_W];
		end
		if (state_q == ST_EVAL) begin
			steady_q <= steady_c;
			excess_q <= excess_c;
			if (in_range && (is_switch || active_q[idx])) begin
				res_q <= switch_limit_q;
			end else begin
				res_q <= steady_c;
			end
		end
		if (state_q == ST_MUL_DECAY || state_q == ST_MUL_SCALE) begin
			prod_q <= prod_c;
		end
		if (state_q == ST_SUM) begin
			res_q <= (total_c[SUM_W-1:LIMIT_W] != '0) ? '1 : total_c[LIMIT_W-1:0];
		end
		if (out_load) begin
			m_joint_q <= joint_q;
			m_limit_q <= res_q;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = {{M_PAD_W{1'b0}}, m_limit_q, m_joint_q};

endmodule

[src/stls_checker.sv]
// Port-level checker for the torque limit scheduler, bound to the top level.
`include "switched_torque_limit_scheduler_core_assert.svh"

module stls_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [stls_pkg::M_DATA_W-1:0] m_tdata
);
	import stls_pkg::*;

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	// A stalled result item keeps its value.
	`STLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

	// The block works on one item at a time, so it is busy right after accepting one.
	`STLS_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_tready, "input ready right after an accepted item")

	// No result can appear in the cycle that follows an accepted item.
	`STLS_ASSERT_NEXT(a_no_early_result, s_acc, !$rose(m_tvalid), "result appeared too early")

	// Padding above the result fields stays zero.
	`STLS_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[M_DATA_W-1:M_FIELDS_W] == '0, "result padding not zero")

endmodule

bind switched_torque_limit_scheduler_core stls_checker u_stls_checker (.*);
